@@ src/drsp_pkg.sv @@
// ----------------------------------------------------------------------------
// drsp_pkg
// Shared constants and tables for the DES round tail: S-boxes and P table.
// ----------------------------------------------------------------------------
package drsp_pkg;

  localparam int unsigned GroupBits = 6;
  localparam int unsigned HalfBits  = 32;
  localparam int unsigned Groups    = 8;
  localparam int unsigned InBits    = GroupBits * Groups;
  localparam int unsigned OutBits   = 4;

  typedef logic [GroupBits-1:0] grp_t;
  typedef logic [OutBits-1:0]   nib_t;
  typedef logic [2:0]           box_idx_t;
  typedef logic [HalfBits-1:0]  half_t;

  localparam nib_t SBOX [Groups][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  // des bit numbers, 1 is the msb
  localparam logic [5:0] PERM [HalfBits] = '{
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
    6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25
  };

  function automatic half_t perm_fn(input half_t v);
    half_t      res;
    logic [5:0] src;
    res = '0;
    for (int n = 0; n < HalfBits; n++) begin
      src = 6'(HalfBits) - PERM[n];
      res[HalfBits-1-n] = v[src[4:0]];
    end
    return res;
  endfunction

endpackage

@@ src/drsp_sbox_lane.sv @@
// ----------------------------------------------------------------------------
// drsp_sbox_lane
// One s-box lane: 6-bit group in, 4-bit substitution out.
// ----------------------------------------------------------------------------
module drsp_sbox_lane (
  input  drsp_pkg::grp_t     grp_i,
  input  drsp_pkg::box_idx_t box_i,
  output drsp_pkg::nib_t     val_o
);
  import drsp_pkg::*;

  logic [1:0] row;
  logic [3:0] col;

  assign row   = {grp_i[5], grp_i[0]};
  assign col   = grp_i[4:1];
  assign val_o = SBOX[box_i][row][col];

endmodule

@@ src/drsp_perm_xor.sv @@
// ----------------------------------------------------------------------------
// drsp_perm_xor
// Merge stage: p permutation of the lane outputs, xor with the left half.
// ----------------------------------------------------------------------------
module drsp_perm_xor (
  input  drsp_pkg::half_t sub_i,
  input  drsp_pkg::half_t left_i,
  output drsp_pkg::half_t right_o
);
  import drsp_pkg::*;

  assign right_o = left_i ^ perm_fn(sub_i);

endmodule

@@ src/des_round_sbox_perm_xor.sv @@
// ----------------------------------------------------------------------------
// des_round_sbox_perm_xor
// DES round tail: eight parallel s-box lanes, p permutation, xor with left.
//
//   channel   handshake          payload
//   request   start_i / busy_o   sbox_input_i[47:0], left_half_i[31:0]
//   result    done_o (strobe)    new_right_o[31:0]
//
// one request per cycle; busy_o is always low.
// lane outputs are registered first, then the merged result is registered.
// reset clears only the valid pipeline; payload registers are not reset.
// results cannot be stalled; each is shown for one cycle with done_o.
// ----------------------------------------------------------------------------
module des_round_sbox_perm_xor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [drsp_pkg::InBits-1:0] sbox_input_i,
  input  drsp_pkg::half_t           left_half_i,
  output logic                      done_o,
  output drsp_pkg::half_t           new_right_o
);
  import drsp_pkg::*;

  half_t sub_d, sub_q;
  half_t left_q;
  logic  vld_q;
  half_t right_d, right_q;
  logic  done_q;
  logic  req;

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  for (genvar g = 0; g < Groups; g++) begin : g_lane
    drsp_sbox_lane u_lane (
      .grp_i (sbox_input_i[InBits-1-g*GroupBits -: GroupBits]),
      .box_i (box_idx_t'(g)),
      .val_o (sub_d[HalfBits-1-g*OutBits -: OutBits])
    );
  end

  always_ff @(posedge clk_i) begin
    sub_q   <= sub_d;
    left_q  <= left_half_i;
    right_q <= right_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= req;
      done_q <= vld_q;
    end
  end

  drsp_perm_xor u_merge (
    .sub_i   (sub_q),
    .left_i  (left_q),
    .right_o (right_d)
  );

  assign done_o      = done_q;
  assign new_right_o = right_q;

  a_req_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> vld_q) else $error("request not captured in lane stage");

  a_stage_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o) else $error("lane stage did not produce a result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |=> !done_o) else $error("result strobe without a request");

endmodule

@@ dv/drsp_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// drsp_tb_pkg
// Round-tail predictor and result tracker for the des_round_sbox_perm_xor
// testbench. The predictor keeps its own copy of the eight S-boxes and the P
// table. The tracker queues the predicted new right half for every accepted
// request and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drsp_tb_pkg;

  typedef logic [47:0] sbox_in_t;
  typedef logic [31:0] right_t;

  localparam int NumBoxes = 8;
  localparam int RightBits = 32;

  // one entry per box, row-major, row 0 column 0 in the top nibble
  localparam logic [255:0] BOX_NIBS [NumBoxes] = '{
    256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D,
    256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9,
    256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C,
    256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E,
    256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453,
    256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D,
    256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C,
    256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B
  };

  // source bit of each output bit, des numbering with 1 at the msb
  localparam int P_SRC [RightBits] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
  };

  function automatic right_t des_new_right(input sbox_in_t sin, input right_t left);
    right_t     subst;
    right_t     permuted;
    logic [5:0] grp;
    int         idx;
    subst = '0;
    permuted = '0;
    for (int g = 0; g < NumBoxes; g++) begin
      grp = sin[47-6*g -: 6];
      // row from the outer bits, column from the inner four
      idx = {grp[5], grp[0], grp[4:1]};
      subst[31-4*g -: 4] = BOX_NIBS[g][255-4*idx -: 4];
    end
    for (int n = 0; n < RightBits; n++) begin
      permuted[RightBits-1-n] = subst[RightBits-P_SRC[n]];
    end
    return left ^ permuted;
  endfunction

  class new_right_tracker;
    right_t pending_right[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(input sbox_in_t sin, input right_t left);
      pending_right.push_back(des_new_right(sin, left));
    endfunction

    function void check_result(input right_t actual);
      right_t want;
      if (pending_right.size() == 0) begin
        $error("new_right: result with no request waiting, expected none, actual %h",
               actual);
        errors++;
      end else begin
        want = pending_right.pop_front();
        if (actual !== want) begin
          $error("new_right mismatch: expected %h, actual %h", want, actual);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_right.size();
    endfunction
  endclass

endpackage

@@ dv/tb_des_round_sbox_perm_xor.sv @@
// ----------------------------------------------------------------------------
// tb_des_round_sbox_perm_xor
// Self-checking testbench for the DES round tail. Directed corner patterns
// are followed by about 600 random requests in phases with and without
// sender idle cycles. Every accepted request is predicted and each result
// strobe is checked in order; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_des_round_sbox_perm_xor;
  import drsp_tb_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 6;
  localparam int PhaseItems = 150;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  sbox_in_t        sbox_input_i;
  drsp_pkg::half_t left_half_i;
  logic            done_o;
  drsp_pkg::half_t new_right_o;

  new_right_tracker tracker = new();
  int unsigned      stall_cycles = 0;

  des_round_sbox_perm_xor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .sbox_input_i (sbox_input_i),
    .left_half_i  (left_half_i),
    .done_o       (done_o),
    .new_right_o  (new_right_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // request and result monitor, plus watchdog
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      tracker.note_request(sbox_input_i, left_half_i);
    end
    if (rst_ni && done_o) begin
      tracker.check_result(new_right_o);
    end
    if (rst_ni && ((start_i && !busy_o) || done_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("des_round_sbox_perm_xor test failed");
      $finish;
    end
  end

  task automatic send_request(input sbox_in_t sin, input right_t left, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      sbox_input_i <= 48'({$urandom(), $urandom()});
      left_half_i <= $urandom();
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    sbox_input_i <= sin;
    left_half_i <= left;
    @(posedge clk_i iff !busy_o);
  endtask

  function automatic sbox_in_t rand_sbox_in();
    sbox_in_t v;
    v = 48'({$urandom(), $urandom()});
    // sometimes force groups onto the table corners
    if ($urandom_range(7) == 0) begin
      for (int g = 0; g < NumBoxes; g++) begin
        case ($urandom_range(4))
          0: v[47-6*g -: 6] = 6'h00;
          1: v[47-6*g -: 6] = 6'h21;
          2: v[47-6*g -: 6] = 6'h1E;
          3: v[47-6*g -: 6] = 6'h3F;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  function automatic right_t rand_left();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_directed();
    send_request(48'h0, 32'h0, 0);
    send_request('1, '1, 0);
    send_request(48'h0, '1, 0);
    send_request('1, 32'h0, 0);
    send_request(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 0);
    send_request(48'h5555_5555_5555, 32'hAAAA_AAAA, 0);
    send_request(48'h8618_6186_1861, 32'h0, 0);
    send_request(48'h79E7_9E79_E79E, 32'h0, 0);
    send_request(48'h8000_0000_0000, 32'h8000_0000, 0);
    send_request(48'h0000_0000_0001, 32'h0000_0001, 0);
    send_request(48'h0000_0000_0021, 32'h0, 0);
    send_request(48'h8400_0000_0000, 32'h0, 0);
    send_request(48'h0123_4567_89AB, 32'hDEAD_BEEF, 0);
    send_request(48'hFEDC_BA98_7654, 32'h0123_4567, 0);
    for (int g = 0; g < NumBoxes; g++) begin
      send_request(48'hFFFF_FFFF_FFFF ^ (48'h3F << (6*g)), 32'h1 << (4*g), 0);
    end
  endtask

  initial begin
    int idle_pct [4] = '{0, 88, 14, 0};
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    sbox_input_i <= '0;
    left_half_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PhaseItems; i++) begin
        send_request(rand_sbox_in(), rand_left(), idle_pct[p]);
      end
    end
    start_i <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("des_round_sbox_perm_xor test passed");
    end else begin
      $display("des_round_sbox_perm_xor test failed");
    end
    $finish;
  end

endmodule
